[hw/rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the seven-segment display driver
// Command format, phase codes, register indexes, bus bytes, segment table.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int BIDX_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_DIGIT = 2'd2;

    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hC0;
    localparam logic [7:0] CMD_CTRL   = 8'h80;
    localparam logic [7:0] SEG_POINT  = 8'h80;
    localparam logic [15:0] RECIP_10  = 16'd52429;
    localparam int          RECIP_SH  = 19;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S0,
        PH_S1,
        PH_S2,
        PH_BL,
        PH_BH,
        PH_A0,
        PH_A1,
        PH_A2,
        PH_P0,
        PH_P1,
        PH_P2
    } t_phase;

    typedef struct packed {
        logic                       load;
        logic [NUM_DIGITS-1:0][7:0] segs;
    } t_cmd;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy_res;
        logic done_res;
        logic load_ignored;
    } t_res;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_on;
        logic [1:0] point_digit;
    } t_cfg;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'b0011_1111;
            4'd1:    code = 8'b0000_0110;
            4'd2:    code = 8'b0101_1011;
            4'd3:    code = 8'b0100_1111;
            4'd4:    code = 8'b0110_0110;
            4'd5:    code = 8'b0110_1101;
            4'd6:    code = 8'b0111_1101;
            4'd7:    code = 8'b0000_0111;
            4'd8:    code = 8'b0111_1111;
            4'd9:    code = 8'b0110_1111;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/ssd_front.sv]
// ----------------------------------------------------------------------------
// ssd_front: request intake and digit split
// Passes ticks straight on; splits a load's magnitude one digit per cycle, the last waiting on a full queue.
// ----------------------------------------------------------------------------
module ssd_front import ssd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_mode,
    input  logic [15:0] i_value_x100,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic                       r_busy, n_busy;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [15:0]                r_work, n_work;
    logic [NUM_DIGITS-1:0][7:0] r_seg, n_seg;

    logic        w_acc;
    logic        w_last;
    logic        w_adv;
    logic [15:0] w_mag;
    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_rem;
    logic [7:0]  w_code;

    assign o_full = r_busy | i_q_full;
    assign w_acc  = i_push & ~o_full;
    assign w_mag  = i_value_x100[15] ? (~i_value_x100 + 16'd1) : i_value_x100;
    assign w_prod = {16'd0, r_work} * {16'd0, RECIP_10};
    assign w_quot = 16'(w_prod >> RECIP_SH);
    assign w_rem  = r_work - ((w_quot << 3) + (w_quot << 1));
    assign w_code = seg_code(w_rem[3:0]);
    assign w_last = (int'(r_cnt) == NUM_DIGITS - 1);
    assign w_adv  = r_busy & (~w_last | ~i_q_full);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_seg  = r_seg;
        if (w_acc && !i_mode) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_work = w_mag;
        end
        if (w_adv) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (int'(r_cnt) == NUM_DIGITS - 1 - i) begin
                    n_seg[i] = w_code;
                end
            end
            n_work = w_quot;
            n_cnt  = r_cnt + CNT_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_q_push     = (w_acc & i_mode) | (w_adv & w_last);
    assign o_q_cmd.load = r_busy;
    assign o_q_cmd.segs = n_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_seg  <= n_seg;
    end

endmodule

[hw/rtl/ssd_cmd_queue.sv]
// ----------------------------------------------------------------------------
// ssd_cmd_queue: two-entry command queue
// Decouples request intake from the pin sequencer.
// ----------------------------------------------------------------------------
module ssd_cmd_queue import ssd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd       r_ent [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_cmd   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/ssd_back.sv]
// ----------------------------------------------------------------------------
// ssd_back: pin sequencer and result queue
// Runs the three bus transactions one pin phase per tick; queues results.
// ----------------------------------------------------------------------------
module ssd_back import ssd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_phase                     r_phase, n_phase;
    logic [NUM_DIGITS-1:0][7:0] r_seg, n_seg;
    logic [7:0]                 r_shift, n_shift;
    logic [BIDX_W-1:0]          r_bidx, n_bidx;
    logic [2:0]                 r_bit, n_bit;
    logic [1:0]                 r_txn, n_txn;
    logic                       r_active, n_active;
    logic                       r_clk, n_clk;
    logic                       r_dio, n_dio;
    logic                       r_drv, n_drv;

    t_res       r_res_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic              w_step;
    logic              w_res_full;
    logic              w_res_pop;
    logic              w_done;
    logic              w_ignored;
    logic [BIDX_W-1:0] w_bidx_sel;
    logic [BIDX_W-1:0] w_txn_len;
    logic [7:0]        w_byte;
    t_res              w_res;

    assign w_res_full = (r_cnt == 2'd2);
    assign o_empty    = (r_cnt == 2'd0);
    assign w_res_pop  = i_pop & ~o_empty;
    assign w_step     = ~i_cmd_empty & ~w_res_full;
    assign o_cmd_pop  = w_step;
    assign o_res      = r_res_q[r_rd];

    assign w_bidx_sel = (r_phase == PH_A2) ? (r_bidx + BIDX_W'(1)) : r_bidx;
    assign w_txn_len  = (r_txn == 2'd1) ? BIDX_W'(NUM_DIGITS + 1) : BIDX_W'(1);

    always_comb begin
        w_byte = 8'h00;
        if (r_txn == 2'd0) begin
            w_byte = CMD_DATA;
        end else if (r_txn == 2'd2) begin
            w_byte = CMD_CTRL | {4'd0, i_cfg.display_on, i_cfg.brightness};
        end else if (w_bidx_sel == '0) begin
            w_byte = CMD_ADDR;
        end else begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (int'(w_bidx_sel) == i + 1) begin
                    w_byte = r_seg[i];
                end
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_seg     = r_seg;
        n_shift   = r_shift;
        n_bidx    = r_bidx;
        n_bit     = r_bit;
        n_txn     = r_txn;
        n_active  = r_active;
        n_clk     = r_clk;
        n_dio     = r_dio;
        n_drv     = r_drv;
        w_done    = 1'b0;
        w_ignored = 1'b0;
        if (w_step) begin
            if (i_cmd.load) begin
                if (r_active) begin
                    w_ignored = 1'b1;
                end else begin
                    n_seg = i_cmd.segs;
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (int'(i_cfg.point_digit) == i) begin
                            n_seg[i] = i_cmd.segs[i] | SEG_POINT;
                        end
                    end
                    n_active = 1'b1;
                    n_txn    = 2'd0;
                    n_bidx   = '0;
                    n_bit    = 3'd0;
                    n_phase  = PH_S0;
                end
            end else if (r_active) begin
                case (r_phase)
                    PH_S0: begin
                        n_clk   = 1'b1;
                        n_dio   = 1'b1;
                        n_drv   = 1'b1;
                        n_phase = PH_S1;
                    end
                    PH_S1: begin
                        n_dio   = 1'b0;
                        n_phase = PH_S2;
                    end
                    PH_S2: begin
                        n_clk   = 1'b0;
                        n_shift = w_byte;
                        n_bit   = 3'd0;
                        n_phase = PH_BL;
                    end
                    PH_BL: begin
                        n_clk   = 1'b0;
                        n_dio   = r_shift[0];
                        n_phase = PH_BH;
                    end
                    PH_BH: begin
                        n_clk   = 1'b1;
                        n_shift = r_shift >> 1;
                        if (r_bit == 3'd7) begin
                            n_phase = PH_A0;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_phase = PH_BL;
                        end
                    end
                    PH_A0: begin
                        n_clk   = 1'b0;
                        n_drv   = 1'b0;
                        n_phase = PH_A1;
                    end
                    PH_A1: begin
                        n_clk   = 1'b1;
                        n_phase = PH_A2;
                    end
                    PH_A2: begin
                        n_clk  = 1'b0;
                        n_drv  = 1'b1;
                        n_bidx = w_bidx_sel;
                        if (w_bidx_sel < w_txn_len) begin
                            n_shift = w_byte;
                            n_bit   = 3'd0;
                            n_phase = PH_BL;
                        end else begin
                            n_phase = PH_P0;
                        end
                    end
                    PH_P0: begin
                        n_clk   = 1'b0;
                        n_dio   = 1'b0;
                        n_phase = PH_P1;
                    end
                    PH_P1: begin
                        n_clk   = 1'b1;
                        n_phase = PH_P2;
                    end
                    PH_P2: begin
                        n_dio  = 1'b1;
                        n_bidx = '0;
                        if (r_txn == 2'd2) begin
                            n_txn    = 2'd0;
                            n_active = 1'b0;
                            n_phase  = PH_IDLE;
                            w_done   = 1'b1;
                        end else begin
                            n_txn   = r_txn + 2'd1;
                            n_phase = PH_S0;
                        end
                    end
                    default: begin
                        n_active = 1'b0;
                        n_phase  = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign w_res.clk_level    = n_clk;
    assign w_res.dio_level    = n_dio;
    assign w_res.dio_drive    = n_drv;
    assign w_res.busy_res     = n_active;
    assign w_res.done_res     = w_done;
    assign w_res.load_ignored = w_ignored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_seg    <= '0;
            r_shift  <= 8'h00;
            r_bidx   <= '0;
            r_bit    <= 3'd0;
            r_txn    <= 2'd0;
            r_active <= 1'b0;
            r_clk    <= 1'b1;
            r_dio    <= 1'b1;
            r_drv    <= 1'b1;
            r_wr     <= 1'b0;
            r_rd     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_seg    <= n_seg;
            r_shift  <= n_shift;
            r_bidx   <= n_bidx;
            r_bit    <= n_bit;
            r_txn    <= n_txn;
            r_active <= n_active;
            r_clk    <= n_clk;
            r_dio    <= n_dio;
            r_drv    <= n_drv;
            if (w_step) begin
                r_wr <= ~r_wr;
            end
            if (w_res_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_step} - {1'b0, w_res_pop};
        end
        if (w_step) begin
            r_res_q[r_wr] <= w_res;
        end
    end

endmodule

[hw/rtl/seven_segment_two_wire_display_driver.sv]
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver: two-wire seven-segment LED driver
// Loads a value scaled by 100 into four digit codes and clocks them out.
//
// Requests enter through push/full: mode 0 loads i_value_x100, mode 1 is a
// tick that advances the two-wire bus by one pin phase. Every request gives
// exactly one result, read through empty/pop: pin levels, busy, done and a
// flag for a load dropped because an update was still running.
// A tick is written into the command queue when it is taken; the sequencer
// pops it and writes its result into the result queue once that queue has
// room. Ticks stream at one per cycle while neither queue is full. A load
// holds the intake while the digit splitter produces one decimal digit per
// cycle, the last waiting while the command queue is full.
// Configuration (brightness, display_on, point_digit) is written on the
// i_cfg_* port; an unknown index is ignored.
// Reset clears both queues, parks the sequencer idle with clock and data
// high and driven, and restores the register defaults. When the reader
// stops popping, two results and two requests buffer before full rises.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_display_driver import ssd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_mode,
    input  logic signed [15:0]    i_value_x100,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_clk_level,
    output logic                  o_dio_level,
    output logic                  o_dio_drive,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_load_ignored
);

    t_cfg r_cfg;
    logic w_q_full;
    logic w_q_push;
    t_cmd w_q_cmd_in;
    t_cmd w_q_cmd_out;
    logic w_q_empty;
    logic w_q_pop;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness  <= 3'd7;
            r_cfg.display_on  <= 1'b1;
            r_cfg.point_digit <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIGHTNESS:  r_cfg.brightness  <= i_cfg_data;
                REG_DISPLAY_ON:  r_cfg.display_on  <= i_cfg_data[0];
                REG_POINT_DIGIT: r_cfg.point_digit <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    ssd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_value_x100 (i_value_x100),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_q_cmd_in)
    );

    ssd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_q_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd_out),
        .o_empty (w_q_empty)
    );

    ssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_q_cmd_out),
        .i_cmd_empty (w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign o_clk_level    = w_res.clk_level;
    assign o_dio_level    = w_res.dio_level;
    assign o_dio_drive    = w_res.dio_drive;
    assign o_busy_res     = w_res.busy_res;
    assign o_done_res     = w_res.done_res;
    assign o_load_ignored = w_res.load_ignored;

endmodule

[tb/seven_segment_two_wire_display_driver_test.sv]
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver_test: regression of the display driver
// Sends load and tick requests through the push/full side, predicts the pin
// levels, busy, done and dropped-load flags of every request, and compares
// each popped result in order. Covers register extremes, the edge values of
// the scaled input, loads while busy, ticks while idle, backpressure and
// random update sequences under three idling patterns.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_display_driver_test;
    import ssd_pkg::*;

    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TICK      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 8;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    logic                  i_mode         = 1'b0;
    logic signed [15:0]    i_value_x100   = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic                  o_clk_level;
    logic                  o_dio_level;
    logic                  o_dio_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_load_ignored;

    seven_segment_two_wire_display_driver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_mode         (i_mode),
        .i_value_x100   (i_value_x100),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .empty          (empty),
        .pop            (pop),
        .o_clk_level    (o_clk_level),
        .o_dio_level    (o_dio_level),
        .o_dio_drive    (o_dio_drive),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_load_ignored (o_load_ignored)
    );

    // bus sequencer mirror
    logic [2:0] cfg_bright = 3'd7;
    logic       cfg_on     = 1'b1;
    logic [1:0] cfg_point  = 2'd1;
    logic [7:0] digit_bytes [NUM_DIGITS];
    logic [7:0] shift_reg  = '0;
    logic [2:0] byte_num   = '0;
    logic [2:0] bit_num    = '0;
    logic [1:0] txn_num    = '0;
    t_phase     bus_phase  = PH_IDLE;
    logic       pin_clk    = 1'b1;
    logic       pin_dio    = 1'b1;
    logic       pin_drv    = 1'b1;
    logic       upd_active = 1'b0;

    t_res pending_pins [$];

    int tx_idle_pct     = 31;
    int rx_idle_pct     = 58;
    int rx_hold_req     = 0;
    int rx_hold_left    = 0;
    int quiet_cycles    = 0;
    int updates_run     = 0;
    int loads_dropped   = 0;
    int idle_ticks      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bus_byte();
        if (txn_num == 2'd0)
            return CMD_DATA;
        if (txn_num == 2'd2)
            return CMD_CTRL | {4'b0, cfg_on, cfg_bright};
        if (byte_num == 3'd0)
            return CMD_ADDR;
        return digit_bytes[2'(byte_num - 3'd1)];
    endfunction

    task automatic start_byte();
        shift_reg = bus_byte();
        bit_num   = '0;
        bus_phase = PH_BL;
    endtask

    task automatic advance_bus_phase(output logic done);
        done = 1'b0;
        case (bus_phase)
            PH_S0: begin
                pin_clk = 1'b1;
                pin_dio = 1'b1;
                pin_drv = 1'b1;
                bus_phase = PH_S1;
            end
            PH_S1: begin
                pin_dio = 1'b0;
                bus_phase = PH_S2;
            end
            PH_S2: begin
                pin_clk = 1'b0;
                start_byte();
            end
            PH_BL: begin
                pin_clk = 1'b0;
                pin_dio = shift_reg[0];
                bus_phase = PH_BH;
            end
            PH_BH: begin
                pin_clk = 1'b1;
                shift_reg = shift_reg >> 1;
                if (bit_num >= 3'd7) begin
                    bus_phase = PH_A0;
                end else begin
                    bit_num = bit_num + 3'd1;
                    bus_phase = PH_BL;
                end
            end
            PH_A0: begin
                pin_clk = 1'b0;
                pin_drv = 1'b0;
                bus_phase = PH_A1;
            end
            PH_A1: begin
                pin_clk = 1'b1;
                bus_phase = PH_A2;
            end
            PH_A2: begin
                pin_clk = 1'b0;
                pin_drv = 1'b1;
                byte_num = byte_num + 3'd1;
                if (int'(byte_num) < ((txn_num == 2'd1) ? NUM_DIGITS + 1 : 1))
                    start_byte();
                else
                    bus_phase = PH_P0;
            end
            PH_P0: begin
                pin_clk = 1'b0;
                pin_dio = 1'b0;
                bus_phase = PH_P1;
            end
            PH_P1: begin
                pin_clk = 1'b1;
                bus_phase = PH_P2;
            end
            PH_P2: begin
                pin_dio = 1'b1;
                byte_num = '0;
                if (txn_num >= 2'd2) begin
                    txn_num = '0;
                    upd_active = 1'b0;
                    bus_phase = PH_IDLE;
                    done = 1'b1;
                end else begin
                    txn_num = txn_num + 2'd1;
                    bus_phase = PH_S0;
                end
            end
            default: begin
                upd_active = 1'b0;
                bus_phase = PH_IDLE;
            end
        endcase
    endtask

    task automatic predict_request(input logic mode, input logic signed [15:0] val);
        t_res r;
        logic done;
        logic dropped;
        int   mag;
        done    = 1'b0;
        dropped = 1'b0;
        if (mode == MODE_LOAD) begin
            if (upd_active) begin
                dropped = 1'b1;
                loads_dropped++;
            end else begin
                mag = (val < 0) ? -int'(val) : int'(val);
                for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
                    digit_bytes[i] = DIGIT_GLYPH[mag % 10];
                    mag = mag / 10;
                end
                digit_bytes[cfg_point] = digit_bytes[cfg_point] | SEG_POINT;
                upd_active = 1'b1;
                txn_num    = '0;
                byte_num   = '0;
                bit_num    = '0;
                bus_phase  = PH_S0;
                updates_run++;
            end
        end else if (upd_active) begin
            advance_bus_phase(done);
        end else begin
            idle_ticks++;
        end
        r.clk_level    = pin_clk;
        r.dio_level    = pin_dio;
        r.dio_drive    = pin_drv;
        r.busy_res     = upd_active;
        r.done_res     = done;
        r.load_ignored = dropped;
        pending_pins.push_back(r);
    endtask

    task automatic send_request(input logic mode, input logic signed [15:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_mode       <= mode;
        i_value_x100 <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_request(mode, val);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_BRIGHTNESS:  cfg_bright = data;
            REG_DISPLAY_ON:  cfg_on     = data[0];
            REG_POINT_DIGIT: cfg_point  = data[1:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_request(MODE_TICK, 16'h0000);
        send_request(MODE_TICK, 16'hFFFF);
        send_request(MODE_LOAD, 16'h7FFF);
        send_request(MODE_LOAD, 16'h8000);
        while (upd_active) send_request(MODE_TICK, 16'h0000);
    endtask

    task automatic test_register_low_end();
        write_reg(REG_BRIGHTNESS, 3'd0);
        write_reg(REG_DISPLAY_ON, 3'd0);
        write_reg(REG_POINT_DIGIT, 3'd3);
        write_reg(REG_POINT_DIGIT + 2'd1, 3'd7);
        send_request(MODE_LOAD, 16'h8000);
    endtask

    task automatic test_register_high_end();
        write_reg(REG_BRIGHTNESS, 3'd7);
        write_reg(REG_DISPLAY_ON, 3'd1);
        write_reg(REG_POINT_DIGIT, 3'd0);
    endtask

    task automatic test_backpressure();
        write_reg(REG_POINT_DIGIT, 3'd2);
        rx_hold_req = 60;
        repeat (40) send_request(MODE_TICK, 16'($urandom));
    endtask

    task automatic test_drain_pause();
        send_request(MODE_LOAD, pick_value());
        repeat (40) send_request(MODE_TICK, 16'($urandom));
        wait_drained();
        while (upd_active) send_request(MODE_TICK, 16'($urandom));
    endtask

    task automatic test_random_updates(input int tx_pct, input int rx_pct, input int quota);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (quota) begin
            if (!upd_active || $urandom_range(0, 99) < 8)
                send_request(MODE_LOAD, pick_value());
            else
                send_request(MODE_TICK, 16'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && pop && !empty) begin
            results_checked++;
            if (pending_pins.size() == 0) begin
                mismatch_count++;
                $display("%0t: result popped with no request outstanding", $time);
            end else begin
                e = pending_pins.pop_front();
                if (e.clk_level !== o_clk_level || e.dio_level !== o_dio_level ||
                    e.dio_drive !== o_dio_drive || e.busy_res !== o_busy_res ||
                    e.done_res !== o_done_res || e.load_ignored !== o_load_ignored) begin
                    mismatch_count++;
                    $display("%0t: clk/dio/drv/busy/done/ignored expected %b%b%b%b%b%b got %b%b%b%b%b%b",
                             $time, e.clk_level, e.dio_level, e.dio_drive, e.busy_res,
                             e.done_res, e.load_ignored, o_clk_level, o_dio_level,
                             o_dio_drive, o_busy_res, o_done_res, o_load_ignored);
                end
            end
        end
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("seven_segment_two_wire_display_driver regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_low_end();
        test_backpressure();
        test_drain_pause();
        test_register_high_end();
        test_random_updates(31, 58, 40);
        test_random_updates(58, 31, 40);
        test_random_updates(0, 0, 40);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("ran %0d display updates, %0d loads dropped while busy, %0d idle ticks",
                 updates_run, loads_dropped, idle_ticks);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_pins.size() == 0)
            $display("seven_segment_two_wire_display_driver regression: pass");
        else
            $display("seven_segment_two_wire_display_driver regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_front.sv
hw/rtl/ssd_cmd_queue.sv
hw/rtl/ssd_back.sv
hw/rtl/seven_segment_two_wire_display_driver.sv
tb/seven_segment_two_wire_display_driver_test.sv
